>>> sv/llps_pkg.sv
// Shared types and constants for the lookahead lateral PID steering block.
// No dependencies; imported by llps_front, llps_back and the top level.
package llps_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POSE = 1'b1;

  localparam logic [2:0] REG_LINEAR_SPEED   = 3'd0;
  localparam logic [2:0] REG_LOOKAHEAD      = 3'd1;
  localparam logic [2:0] REG_GAIN_P         = 3'd2;
  localparam logic [2:0] REG_GAIN_I         = 3'd3;
  localparam logic [2:0] REG_GAIN_D         = 3'd4;
  localparam logic [2:0] REG_RATE_LIMIT     = 3'd5;
  localparam logic [2:0] REG_INTEGRAL_BOUND = 3'd6;
  localparam logic [2:0] REG_PATH_CAPACITY  = 3'd7;

  localparam int CORDIC_STEPS = 20;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
  localparam int DIV_BITS = 48;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic [47:0]        timestamp;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] angular_rate;
    logic [30:0]        forward_speed;
    logic signed [31:0] lateral_offset;
  } result_t;

  typedef struct packed {
    logic [30:0]        look_radius;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic [30:0]        rate_limit;
    logic [30:0]        integral_bound;
  } ctl_cfg_t;

  function automatic logic [29:0] atan_step(input logic [4:0] i);
    logic [29:0] a;
    unique case (i)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

>>> sv/llps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module llps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/llps_front.sv
// Front end: accepts beats, keeps the path ring pointers and writes points.
// Hands pose updates to the back end through a one-entry queue. Uses llps_pkg.
module llps_front #(
  parameter int PATH_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                operation,
  input  llps_pkg::pose_t                     pose,
  input  logic [8:0]                          path_capacity,
  input  logic                                scan_busy,
  output logic                                we,
  output logic [$clog2(PATH_DEPTH)-1:0]       waddr,
  output logic [63:0]                         wdata,
  output logic                                pend_valid,
  input  logic                                pend_take,
  output llps_pkg::pose_t                     pend_pose,
  output logic [$clog2(PATH_DEPTH)-1:0]       pend_oldest,
  output logic [$clog2(PATH_DEPTH+1)-1:0]     pend_count
);
  import llps_pkg::*;

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int CW = $clog2(PATH_DEPTH + 1);
  localparam int MW = (CW > 9) ? CW : 9;

  logic [AW-1:0] oldest;
  logic [CW-1:0] count;
  logic          accept;
  logic [MW-1:0] cap_ext;
  logic [MW-1:0] cap_eff;
  logic [CW:0]   slot_sum;

  assign full   = pend_valid || scan_busy;
  assign accept = push && !full;

  always_comb begin
    cap_ext = MW'(path_capacity);
    priority if (cap_ext == '0) begin
      cap_eff = MW'(1);
    end else if (cap_ext > MW'(PATH_DEPTH)) begin
      cap_eff = MW'(PATH_DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
    slot_sum = (CW+1)'(oldest) + (CW+1)'(count);
    if (slot_sum >= (CW+1)'(PATH_DEPTH)) begin
      slot_sum = slot_sum - (CW+1)'(PATH_DEPTH);
    end
  end

  assign we    = accept && (operation == OP_PUSH);
  assign waddr = slot_sum[AW-1:0];
  assign wdata = {pose.pos_x, pose.pos_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest     <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_take) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        if (operation == OP_PUSH) begin
          if (MW'(count) >= cap_eff) begin
            oldest <= (oldest == AW'(PATH_DEPTH - 1)) ? '0 : oldest + AW'(1);
          end else begin
            count <= count + CW'(1);
          end
        end else begin
          pend_valid  <= 1'b1;
          pend_pose   <= pose;
          pend_oldest <= oldest;
          pend_count  <= count;
        end
      end
    end
  end

endmodule

>>> sv/llps_back.sv
// Back end: lookahead scan over the path RAM, CORDIC sin/cos, lateral error,
// bit-serial derivative divide and PID. Uses llps_pkg.
module llps_back #(
  parameter int PATH_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pend_valid,
  output logic                             pend_take,
  input  llps_pkg::pose_t                  pend_pose,
  input  logic [$clog2(PATH_DEPTH)-1:0]    pend_oldest,
  input  logic [$clog2(PATH_DEPTH+1)-1:0]  pend_count,
  output logic                             scan_busy,
  output logic [$clog2(PATH_DEPTH)-1:0]    raddr,
  input  logic [63:0]                      rdata,
  input  llps_pkg::ctl_cfg_t               cfg,
  input  logic                             res_ready,
  output logic                             res_valid,
  output logic signed [31:0]               res_rate,
  output logic signed [31:0]               res_error
);
  import llps_pkg::*;

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int CW = $clog2(PATH_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_WAIT, S_DIFF, S_SQ, S_CMP, S_COR, S_CLMP, S_M1, S_M2, S_LAT,
    S_INC1, S_INC2, S_INTG, S_DIV, S_DRV, S_PM, S_IM, S_DM, S_SUM, S_EMIT
  } state_t;

  state_t state;
  pose_t  cur;
  logic [CW-1:0] k, cnt_s;
  logic [61:0] look2;
  logic [31:0] ax, ay;
  logic [63:0] sx, sy;
  logic signed [32:0] dx, dy;
  logic signed [33:0] cx, cy, cz;
  logic [4:0]  ci;
  logic        flip;
  logic signed [31:0] sn, cs;
  logic signed [64:0] p1, p2;
  logic signed [31:0] e, integ, deriv, rate;
  logic [47:0] dt;
  logic        big;
  logic [55:0] pl, ph;
  logic [47:0] dq, dr;
  logic [5:0]  dcnt;
  logic        dneg;
  logic signed [63:0] mp, mi, md;
  logic signed [31:0] integral_sum, prev_error;
  logic [47:0] prev_time;

  logic signed [32:0] dxw, dyw;
  logic [32:0] mxw, myw;
  logic [64:0] sq_sum;
  logic        hit;
  logic signed [33:0] zi, xs, ys, at, xf, yf;
  logic signed [66:0] lsum, lsh;
  logic [31:0] mag;
  logic [79:0] prod;
  logic [63:0] incr;
  logic [33:0] incm;
  logic signed [35:0] integ36, bnd36;
  logic signed [32:0] ediff;
  logic [32:0] ediff_mag;
  logic [48:0] rem_s;
  logic signed [47:0] rp, ri, rd;
  logic signed [49:0] total, rlim;

  always_comb begin
    dxw = $signed({rdata[63], rdata[63:32]}) - $signed({cur.pos_x[31], cur.pos_x});
    dyw = $signed({rdata[31], rdata[31:0]}) - $signed({cur.pos_y[31], cur.pos_y});
    mxw = dxw[32] ? 33'(-dxw) : 33'(dxw);
    myw = dyw[32] ? 33'(-dyw) : 33'(dyw);
    sq_sum = 65'(sx) + 65'(sy);
    hit = sq_sum[64] || (sq_sum[63:0] >= 64'(look2));

    zi = $signed({{2{cur.heading[15]}}, cur.heading, 16'b0});
    xs = cx >>> ci;
    ys = cy >>> ci;
    at = $signed(34'(atan_step(ci)));
    xf = flip ? -cx : cx;
    yf = flip ? -cy : cy;

    lsum = 67'(p2) - 67'(p1) + 67'sd536870912;
    lsh  = lsum >>> 30;

    mag  = e[31] ? (~e + 32'd1) : e;
    prod = {ph, 24'b0} + 80'(pl);
    incr = 64'((prod + 80'd32768) >> 16);
    incm = (big || (incr > 64'h2_0000_0000)) ? 34'h2_0000_0000 : incr[33:0];
    integ36 = 36'(integral_sum) + (e[31] ? -$signed({2'b0, incm}) : $signed({2'b0, incm}));
    bnd36 = $signed({5'b0, cfg.integral_bound});
    ediff = 33'(e) - 33'(prev_error);
    ediff_mag = ediff[32] ? 33'(-ediff) : 33'(ediff);

    rem_s = {dr, dq[47]};

    rp = 48'((mp + 64'sd32768) >>> 16);
    ri = 48'((mi + 64'sd32768) >>> 16);
    rd = 48'((md + 64'sd32768) >>> 16);
    total = 50'(rp) + 50'(ri) + 50'(rd);
    rlim = $signed({19'b0, cfg.rate_limit});
  end

  assign pend_take = (state == S_IDLE) && pend_valid;
  assign scan_busy = (state == S_WAIT) || (state == S_DIFF) || (state == S_SQ) ||
                     (state == S_CMP);
  assign res_valid = (state == S_EMIT) && res_ready;
  assign res_rate  = rate;
  assign res_error = e;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      integral_sum <= '0;
      prev_error   <= '0;
      prev_time    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pend_valid) begin
            cur   <= pend_pose;
            cnt_s <= pend_count;
            raddr <= pend_oldest;
            k     <= '0;
            look2 <= 62'(cfg.look_radius) * 62'(cfg.look_radius);
            if (pend_count != '0 && pend_pose.timestamp > prev_time) begin
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: state <= S_DIFF;
        S_DIFF: begin
          ax    <= mxw[31:0];
          ay    <= myw[31:0];
          state <= S_SQ;
        end
        S_SQ: begin
          sx    <= 64'(ax) * 64'(ax);
          sy    <= 64'(ay) * 64'(ay);
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit || (k == cnt_s - CW'(1))) begin
            dx <= dxw;
            dy <= dyw;
            cy <= '0;
            cx <= CORDIC_GAIN;
            ci <= '0;
            priority if (zi > Q30_ONE) begin
              cz <= zi - (Q30_ONE <<< 1);
              flip <= 1'b1;
            end else if (zi < -Q30_ONE) begin
              cz <= zi + (Q30_ONE <<< 1);
              flip <= 1'b1;
            end else begin
              cz <= zi;
              flip <= 1'b0;
            end
            state <= S_COR;
          end else begin
            k     <= k + CW'(1);
            raddr <= (raddr == AW'(PATH_DEPTH - 1)) ? '0 : raddr + AW'(1);
            state <= S_WAIT;
          end
        end
        S_COR: begin
          if (!cz[33]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end
          ci <= ci + 5'd1;
          if (ci == 5'(CORDIC_STEPS - 1)) begin
            state <= S_CLMP;
          end
        end
        S_CLMP: begin
          cs <= (xf > Q30_ONE) ? 32'(Q30_ONE) : ((xf < -Q30_ONE) ? 32'(-Q30_ONE) : 32'(xf));
          sn <= (yf > Q30_ONE) ? 32'(Q30_ONE) : ((yf < -Q30_ONE) ? 32'(-Q30_ONE) : 32'(yf));
          state <= S_M1;
        end
        S_M1: begin
          p1    <= 65'(dx) * 65'(sn);
          state <= S_M2;
        end
        S_M2: begin
          p2    <= 65'(dy) * 65'(cs);
          dt    <= cur.timestamp - prev_time;
          state <= S_LAT;
        end
        S_LAT: begin
          if (lsh > 67'sd2147483647) begin
            e <= 32'h7FFF_FFFF;
          end else if (lsh < -67'sd2147483648) begin
            e <= 32'h8000_0000;
          end else begin
            e <= 32'(lsh);
          end
          state <= S_INC1;
        end
        S_INC1: begin
          pl    <= 56'(mag) * 56'(dt[23:0]);
          big   <= (mag >= 32'd65536) && (dt >= 48'h2_0000_0000);
          state <= S_INC2;
        end
        S_INC2: begin
          ph    <= 56'(mag) * 56'(dt[47:24]);
          state <= S_INTG;
        end
        S_INTG: begin
          if (integ36 > bnd36) begin
            integ <= 32'(bnd36);
          end else if (integ36 < -bnd36) begin
            integ <= 32'(-bnd36);
          end else begin
            integ <= 32'(integ36);
          end
          dq    <= {ediff_mag[31:0], 16'b0};
          dr    <= '0;
          dneg  <= ediff[32];
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem_s >= 49'(dt)) begin
            dr <= 48'(rem_s - 49'(dt));
            dq <= {dq[46:0], 1'b1};
          end else begin
            dr <= rem_s[47:0];
            dq <= {dq[46:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(DIV_BITS - 1)) begin
            state <= S_DRV;
          end
        end
        S_DRV: begin
          if (dneg) begin
            deriv <= (dq > 48'h8000_0000) ? 32'h8000_0000 : 32'(-dq);
          end else begin
            deriv <= (dq > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : dq[31:0];
          end
          state <= S_PM;
        end
        S_PM: begin
          mp    <= 64'(cfg.gain_p) * 64'(e);
          state <= S_IM;
        end
        S_IM: begin
          mi    <= 64'(cfg.gain_i) * 64'(integ);
          state <= S_DM;
        end
        S_DM: begin
          md    <= 64'(cfg.gain_d) * 64'(deriv);
          state <= S_SUM;
        end
        S_SUM: begin
          if (total > rlim) begin
            rate <= 32'(rlim);
          end else if (total < -rlim) begin
            rate <= 32'(-rlim);
          end else begin
            rate <= 32'(total);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            integral_sum <= integ;
            prev_error   <= e;
            prev_time    <= cur.timestamp;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/lookahead_lateral_pid_steering_top.sv
// Top level: register port, path RAM, front and back ends, result queue.
// Depends on llps_pkg, llps_ram, llps_front and llps_back.
//
// A path push writes its point into the path RAM as it is accepted. A pose
// update scans the stored path points (up to the stored count) through the
// single RAM read port, then runs the 20-step CORDIC, the 48-step serial
// divide and the PID multiplies. While a scan runs, or a pose waits for the
// back end, the input reports full; after the scan the next beats are
// accepted while the pose finishes. Two finished results can wait on the
// output side.
module lookahead_lateral_pid_steering_top #(
  parameter int PATH_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic               operation,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] heading,
  input  logic [47:0]        timestamp,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] angular_rate,
  output logic [30:0]        forward_speed,
  output logic signed [31:0] lateral_offset
);
  import llps_pkg::*;

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int CW = $clog2(PATH_DEPTH + 1);

  logic [30:0] linear_speed;
  logic [8:0]  path_capacity;
  ctl_cfg_t    cfg;
  logic [2:0]  reg_idx;
  logic        wr;

  pose_t         pose, pend_pose;
  logic          pend_valid, pend_take, scan_busy, we;
  logic [AW-1:0] waddr, raddr, pend_oldest;
  logic [CW-1:0] pend_count;
  logic [63:0]   wdata, rdata;
  logic          res_ready, res_valid;
  logic signed [31:0] res_rate, res_error;

  result_t    q0, q1, nres;
  logic [1:0] qcnt;
  logic       pop_acc;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_speed           <= 31'd32768;
      cfg.look_radius        <= 31'd65536;
      cfg.gain_p             <= 32'sd65536;
      cfg.gain_i             <= 32'sd6554;
      cfg.gain_d             <= 32'sd3277;
      cfg.rate_limit         <= 31'd131072;
      cfg.integral_bound     <= 31'd65536;
      path_capacity          <= 9'd200;
    end else if (wr) begin
      unique case (reg_idx)
        REG_LINEAR_SPEED:   linear_speed           <= pwdata[30:0];
        REG_LOOKAHEAD:      cfg.look_radius        <= pwdata[30:0];
        REG_GAIN_P:         cfg.gain_p             <= pwdata;
        REG_GAIN_I:         cfg.gain_i             <= pwdata;
        REG_GAIN_D:         cfg.gain_d             <= pwdata;
        REG_RATE_LIMIT:     cfg.rate_limit         <= pwdata[30:0];
        REG_INTEGRAL_BOUND: cfg.integral_bound     <= pwdata[30:0];
        REG_PATH_CAPACITY:  path_capacity          <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LINEAR_SPEED:   prdata = {1'b0, linear_speed};
      REG_LOOKAHEAD:      prdata = {1'b0, cfg.look_radius};
      REG_GAIN_P:         prdata = cfg.gain_p;
      REG_GAIN_I:         prdata = cfg.gain_i;
      REG_GAIN_D:         prdata = cfg.gain_d;
      REG_RATE_LIMIT:     prdata = {1'b0, cfg.rate_limit};
      REG_INTEGRAL_BOUND: prdata = {1'b0, cfg.integral_bound};
      REG_PATH_CAPACITY:  prdata = {23'b0, path_capacity};
      default:            prdata = '0;
    endcase
  end

  assign pose = '{pos_x: pos_x, pos_y: pos_y, heading: heading, timestamp: timestamp};

  llps_front #(.PATH_DEPTH(PATH_DEPTH)) u_front (
    .clk, .rst, .push, .full, .operation, .pose, .path_capacity, .scan_busy,
    .we, .waddr, .wdata, .pend_valid, .pend_take, .pend_pose, .pend_oldest,
    .pend_count
  );

  llps_ram #(.WIDTH(64), .DEPTH(PATH_DEPTH)) u_path (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  llps_back #(.PATH_DEPTH(PATH_DEPTH)) u_back (
    .clk, .rst, .pend_valid, .pend_take, .pend_pose, .pend_oldest, .pend_count,
    .scan_busy, .raddr, .rdata, .cfg, .res_ready, .res_valid, .res_rate,
    .res_error
  );

  // two-entry result queue
  assign nres = '{angular_rate: res_rate, forward_speed: linear_speed,
                  lateral_offset: res_error};
  assign res_ready = (qcnt != 2'd2);
  assign empty     = (qcnt == 2'd0);
  assign pop_acc   = pop && !empty;
  assign angular_rate   = q0.angular_rate;
  assign forward_speed  = q0.forward_speed;
  assign lateral_offset = q0.lateral_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= 2'd0;
    end else begin
      priority if (pop_acc && res_valid) begin
        if (qcnt == 2'd1) begin
          q0 <= nres;
        end else begin
          q0 <= q1;
          q1 <= nres;
        end
      end else if (pop_acc) begin
        q0   <= q1;
        qcnt <= qcnt - 2'd1;
      end else if (res_valid) begin
        if (qcnt == 2'd0) begin
          q0 <= nres;
        end else begin
          q1 <= nres;
        end
        qcnt <= qcnt + 2'd1;
      end else begin
        qcnt <= qcnt;
      end
    end
  end

endmodule
